[design/lesc_pkg.sv]
package lesc_pkg;

   localparam int unsigned LANE_BITS = 3;
   localparam int unsigned SLOT_BITS = 6;

   typedef enum logic [1:0] {
      KIND_EVENT      = 2'd0,
      KIND_MISS       = 2'd1,
      KIND_TRANSITION = 2'd2
   } kind_type;

   typedef enum logic [0:0] {
      CSR_LANE_ENABLE   = 1'b0,
      CSR_EXPECT_HEADER = 1'b1
   } csr_index_type;

   // classified item handed from the front to the back
   typedef struct packed {
      kind_type               kind;
      logic                   lane_off;
      logic                   hdr;
      logic [LANE_BITS-1:0]   lane;
      logic [21:0]            size;
      logic [SLOT_BITS-1:0]   slot;
      logic [63:0]            pid;
      logic [63:0]            ts;
      logic [23:0]            ecount;
      logic [31:0]            pkt;
   } item_type;

   typedef struct packed {
      kind_type     kind;
      logic [7:0]   flags;
      logic [63:0]  pstep;
      logic [31:0]  cstep;
      logic [31:0]  events;
      logic [63:0]  bytes;
      logic [31:0]  misses;
      logic [31:0]  drops;
      logic [31:0]  exceptions;
      logic [31:0]  slot_count;
   } result_type;

endpackage

[design/lesc_front.sv]
module lesc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [21:0]         buffer_size,
   input  logic [7:0]          destination,
   input  logic [5:0]          buffer_slot,
   input  logic [63:0]         pulse_id,
   input  logic [63:0]         time_stamp,
   input  logic [31:0]         event_word,
   input  logic [31:0]         packet_counter,
   input  logic                csr_valid,
   input  logic [0:0]          csr_index,
   input  logic [31:0]         csr_data,
   output lesc_pkg::item_type  item
);

   logic [7:0] lane_enable_ff;
   logic       expect_header_ff;
   logic [2:0] lane;

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_enable_ff   <= 8'd1;
         expect_header_ff <= 1'b0;
      end else if (csr_valid) begin
         case (lesc_pkg::csr_index_type'(csr_index))
            lesc_pkg::CSR_LANE_ENABLE:   lane_enable_ff   <= csr_data[7:0];
            lesc_pkg::CSR_EXPECT_HEADER: expect_header_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign lane = destination[7:5];

   always_comb begin
      item.size     = buffer_size;
      item.lane     = lane;
      item.slot     = buffer_slot;
      item.pid      = pulse_id;
      item.ts       = time_stamp;
      item.ecount   = event_word[23:0];
      item.pkt      = packet_counter;
      item.hdr      = expect_header_ff;
      item.lane_off = ~lane_enable_ff[lane];
      if (buffer_size == 22'd0) begin
         item.kind = lesc_pkg::KIND_MISS;
      end else if (expect_header_ff && (pulse_id[63:56] != 8'd0)) begin
         item.kind = lesc_pkg::KIND_TRANSITION;
      end else begin
         item.kind = lesc_pkg::KIND_EVENT;
      end
      if (!in_valid) item.kind = lesc_pkg::KIND_EVENT;
   end

endmodule

[design/lesc_back.sv]
module lesc_back #(
   parameter int unsigned NUM_LANES  = 8,
   parameter int unsigned SLOT_COUNT = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  lesc_pkg::item_type    item,
   output lesc_pkg::result_type  result
);

   localparam int unsigned LI_BITS    = (NUM_LANES > 1) ? $clog2(NUM_LANES) : 1;
   // the slot field is six bits wide, so at most 64 counters are reachable
   localparam int unsigned HIST_DEPTH = (SLOT_COUNT < 64) ? SLOT_COUNT : 64;
   localparam int unsigned HIST_BITS  = $clog2(HIST_DEPTH);

   logic [21:0] last_size_ff  [NUM_LANES];
   logic [63:0] last_pulse_ff [NUM_LANES];
   logic [63:0] last_step_ff  [NUM_LANES];
   logic [63:0] last_time_ff  [NUM_LANES];
   logic [23:0] last_ec_ff    [NUM_LANES];
   logic [31:0] last_pkt_ff   [NUM_LANES];
   logic [31:0] hist_mem      [HIST_DEPTH];
   logic [HIST_DEPTH-1:0] seen_ff;
   logic [31:0] events_ff, misses_ff, drops_ff, exc_ff;
   logic [63:0] bytes_ff;
   logic [31:0] events_in, misses_in, drops_in, exc_in;
   logic [63:0] bytes_in;

   logic [LI_BITS-1:0]   li;
   logic [HIST_BITS-1:0] rd_addr;
   logic        slot_ok;
   logic [7:0]  flags;
   logic [63:0] pstep;
   logic [31:0] cstep;
   logic        is_event;

   lesc_pkg::result_type stage_ff;
   logic                 inc_ff, slot_ok_ff, rd_seen_ff, wr_en_ff;
   logic [HIST_BITS-1:0] slot_ff, wr_addr_ff;
   logic [31:0]          rd_data_ff, wr_data_ff, base_cnt, slot_cnt;

   always_comb begin
      li = '0;
      for (int i = 0; i < 8; i++) begin
         if (item.lane == 3'(i)) li = LI_BITS'(i % NUM_LANES);
      end
      slot_ok = 32'(item.slot) < SLOT_COUNT;
      rd_addr = item.slot[HIST_BITS-1:0];
   end

   always_comb begin
      is_event = go && (item.kind == lesc_pkg::KIND_EVENT);
      flags = 8'd0;
      pstep = 64'd0;
      cstep = 32'd0;
      flags[0] = item.size != last_size_ff[li];
      flags[1] = (32'(item.lane) >= NUM_LANES) || item.lane_off;
      if (item.hdr) begin
         pstep    = item.pid - last_pulse_ff[li];
         flags[4] = item.pid < last_pulse_ff[li];
         flags[5] = pstep != last_step_ff[li];
         flags[6] = item.ts < last_time_ff[li];
         cstep    = 32'(item.ecount) - 32'(last_ec_ff[li]);
         flags[7] = cstep != 32'd1;
      end
      flags[2] = item.pkt < last_pkt_ff[li];
      flags[3] = !flags[2] && (item.pkt != last_pkt_ff[li] + 32'd1);
      events_in = events_ff;
      bytes_in  = bytes_ff;
      misses_in = misses_ff;
      drops_in  = drops_ff;
      exc_in    = exc_ff;
      if (go && item.kind == lesc_pkg::KIND_MISS) misses_in = misses_ff + 32'd1;
      if (is_event) begin
         events_in = events_ff + 32'd1;
         bytes_in  = bytes_ff + 64'(item.size);
         if (flags[3]) drops_in = drops_ff + item.pkt - last_pkt_ff[li] - 32'd1;
         if (flags != 8'd0) exc_in = exc_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         events_ff <= '0;
         bytes_ff  <= '0;
         misses_ff <= '0;
         drops_ff  <= '0;
         exc_ff    <= '0;
         for (int i = 0; i < NUM_LANES; i++) begin
            last_size_ff[i]  <= '0;
            last_pulse_ff[i] <= '0;
            last_step_ff[i]  <= '0;
            last_time_ff[i]  <= '0;
            last_ec_ff[i]    <= '0;
            last_pkt_ff[i]   <= '0;
         end
         seen_ff  <= '0;
         inc_ff   <= 1'b0;
         wr_en_ff <= 1'b0;
      end else begin
         events_ff <= events_in;
         bytes_ff  <= bytes_in;
         misses_ff <= misses_in;
         drops_ff  <= drops_in;
         exc_ff    <= exc_in;
         if (go && item.kind != lesc_pkg::KIND_MISS) last_size_ff[li] <= item.size;
         if (is_event) begin
            last_pkt_ff[li] <= item.pkt;
            if (item.hdr) begin
               last_pulse_ff[li] <= item.pid;
               last_step_ff[li]  <= pstep;
               last_time_ff[li]  <= item.ts;
               last_ec_ff[li]    <= item.ecount;
            end
         end
         inc_ff   <= is_event && slot_ok;
         wr_en_ff <= inc_ff;
         if (inc_ff) seen_ff[slot_ff] <= 1'b1;
      end
   end

   // histogram: read at the transfer edge, written back at the following edge
   always_ff @(posedge clock) begin
      rd_data_ff <= hist_mem[rd_addr];
      if (inc_ff) hist_mem[slot_ff] <= slot_cnt;
   end

   always_ff @(posedge clock) begin
      slot_ff    <= rd_addr;
      slot_ok_ff <= slot_ok;
      rd_seen_ff <= seen_ff[rd_addr];
      wr_addr_ff <= slot_ff;
      wr_data_ff <= slot_cnt;
      stage_ff.kind       <= item.kind;
      stage_ff.flags      <= is_event ? flags : 8'd0;
      stage_ff.pstep      <= is_event ? pstep : 64'd0;
      stage_ff.cstep      <= is_event ? cstep : 32'd0;
      stage_ff.events     <= events_in;
      stage_ff.bytes      <= bytes_in;
      stage_ff.misses     <= misses_in;
      stage_ff.drops      <= drops_in;
      stage_ff.exceptions <= exc_in;
      stage_ff.slot_count <= '0;
   end

   always_comb begin
      // the previous count may still be on its way into the memory
      if (wr_en_ff && (wr_addr_ff == slot_ff)) base_cnt = wr_data_ff;
      else if (rd_seen_ff) base_cnt = rd_data_ff;
      else base_cnt = 32'd0;
      slot_cnt = slot_ok_ff ? base_cnt + 32'(inc_ff) : 32'd0;
      result = stage_ff;
      result.slot_count = slot_cnt;
   end

endmodule

[design/lane_event_stream_checker_core.sv]
// channel | ports                       | transfer when
// req     | req_push, req_full, fields  | req_push && !req_full
// rsp     | rsp_pop, rsp_empty, fields  | rsp_pop && !rsp_empty
// csr     | csr_valid, csr_ready, index | csr_valid && csr_ready
// one item per cycle while req is not full: the front classifies, the back
// updates lane state and totals at the transfer edge and finishes the slot
// count in the next cycle, when the result enters a two-entry queue.
// results leave through the queue to the rsp ports; a full queue stalls req.
// reset clears totals, lane tables, histogram marks and the queue.
module lane_event_stream_checker_core #(
   parameter int unsigned NUM_LANES  = 8,
   parameter int unsigned SLOT_COUNT = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   output logic         req_full,
   input  logic [21:0]  req_buffer_size,
   input  logic [7:0]   req_destination,
   input  logic [5:0]   req_buffer_slot,
   input  logic [63:0]  req_pulse_id,
   input  logic [63:0]  req_time_stamp,
   input  logic [31:0]  req_event_word,
   input  logic [31:0]  req_packet_counter,
   output logic         rsp_empty,
   input  logic         rsp_pop,
   output logic [1:0]   rsp_item_kind,
   output logic [7:0]   rsp_check_flags,
   output logic [63:0]  rsp_pulse_step,
   output logic [31:0]  rsp_count_step,
   output logic [31:0]  rsp_total_events,
   output logic [63:0]  rsp_total_bytes,
   output logic [31:0]  rsp_total_misses,
   output logic [31:0]  rsp_total_drops,
   output logic [31:0]  rsp_total_exceptions,
   output logic [31:0]  rsp_slot_use_count,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [0:0]   csr_index,
   input  logic [31:0]  csr_data
);

   lesc_pkg::item_type   item;
   lesc_pkg::result_type res;
   lesc_pkg::result_type q_ff [2];
   logic       go, pop, fresh_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       wr_ff, rd_ff;

   // slot reserved per accepted item: at most two in queue or in flight
   assign req_full  = (32'(cnt_ff) + 32'(fresh_ff) >= 32'd2) && !pop;
   assign go        = req_push && !req_full;
   assign csr_ready = 1'b1;
   assign rsp_empty = cnt_ff == 2'd0;
   assign pop       = rsp_pop && !rsp_empty;

   lesc_front u_front (
      .clock, .reset, .in_valid(go),
      .buffer_size(req_buffer_size), .destination(req_destination),
      .buffer_slot(req_buffer_slot), .pulse_id(req_pulse_id),
      .time_stamp(req_time_stamp), .event_word(req_event_word),
      .packet_counter(req_packet_counter),
      .csr_valid(csr_valid), .csr_index, .csr_data, .item
   );

   lesc_back #(.NUM_LANES(NUM_LANES), .SLOT_COUNT(SLOT_COUNT)) u_back (
      .clock, .reset, .go, .item, .result(res)
   );

   always_comb begin
      cnt_in = cnt_ff + 2'(fresh_ff) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= 1'b0;
         cnt_ff   <= '0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         fresh_ff <= go;
         cnt_ff   <= cnt_in;
         if (fresh_ff) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fresh_ff) q_ff[wr_ff] <= res;
   end

   always_comb begin
      rsp_item_kind        = q_ff[rd_ff].kind;
      rsp_check_flags      = q_ff[rd_ff].flags;
      rsp_pulse_step       = q_ff[rd_ff].pstep;
      rsp_count_step       = q_ff[rd_ff].cstep;
      rsp_total_events     = q_ff[rd_ff].events;
      rsp_total_bytes      = q_ff[rd_ff].bytes;
      rsp_total_misses     = q_ff[rd_ff].misses;
      rsp_total_drops      = q_ff[rd_ff].drops;
      rsp_total_exceptions = q_ff[rd_ff].exceptions;
      rsp_slot_use_count   = q_ff[rd_ff].slot_count;
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(cnt_ff == 2'd2 && fresh_ff && !pop))
      else $error("result queue overflow");
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      go |=> fresh_ff)
      else $error("accepted item lost");
   a_full_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 && !pop |-> req_full)
      else $error("input taken with queue full");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

   typedef struct {
      logic [21:0] size;
      logic [7:0]  dest;
      logic [5:0]  slot;
      logic [63:0] pid;
      logic [63:0] ts;
      logic [31:0] evw;
      logic [31:0] pkt;
   } buffer_desc;

   typedef struct {
      lesc_pkg::kind_type kind;
      logic [7:0]  flags;
      logic [63:0] pstep;
      logic [31:0] cstep;
      logic [31:0] events;
      logic [63:0] bytes;
      logic [31:0] misses;
      logic [31:0] drops;
      logic [31:0] exceptions;
      logic [31:0] slot_count;
   } lane_report;

   // directed row: optional typed-in expectation
   typedef struct {
      buffer_desc desc;
      bit         known;
      lane_report want;
   } directed_row;

   logic clock = 0, reset = 1;
   logic req_push = 0;
   logic req_full;
   logic [21:0] req_buffer_size = 0;
   logic [7:0] req_destination = 0;
   logic [5:0] req_buffer_slot = 0;
   logic [63:0] req_pulse_id = 0, req_time_stamp = 0;
   logic [31:0] req_event_word = 0, req_packet_counter = 0;
   logic rsp_empty;
   logic rsp_pop = 0;
   logic [1:0] rsp_item_kind;
   logic [7:0] rsp_check_flags;
   logic [63:0] rsp_pulse_step, rsp_total_bytes;
   logic [31:0] rsp_count_step, rsp_total_events, rsp_total_misses, rsp_total_drops;
   logic [31:0] rsp_total_exceptions, rsp_slot_use_count;
   logic csr_valid = 0;
   logic csr_ready;
   logic [0:0] csr_index = lesc_pkg::CSR_LANE_ENABLE;
   logic [31:0] csr_data = 0;

   lane_event_stream_checker_core uut (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   // predictor state
   logic [7:0]  lane_mask;
   logic        hdr_on;
   logic [21:0] lane_size [8];
   logic [63:0] lane_pid [8];
   logic [63:0] lane_pstep [8];
   logic [63:0] lane_ts [8];
   logic [23:0] lane_count [8];
   logic [31:0] lane_pkt [8];
   logic [31:0] slot_hist [64];
   logic [31:0] n_events, n_misses, n_drops, n_exceptions;
   logic [63:0] n_bytes;

   lane_report  expected_reports[$];
   int          errors = 0;
   bit          hold_off = 0;
   bit          quiet = 0;

   function automatic lane_report check_buffer(buffer_desc d);
      lane_report r;
      logic [2:0] ln;
      logic [23:0] ec;
      ln = d.dest[7:5];
      ec = d.evw[23:0];
      r.kind = lesc_pkg::KIND_EVENT;
      r.flags = 0;
      r.pstep = 0;
      r.cstep = 0;
      if (d.size == 0) begin
         n_misses++;
         r.kind = lesc_pkg::KIND_MISS;
      end else begin
         if (d.size != lane_size[ln]) begin
            r.flags[0] = 1;
            lane_size[ln] = d.size;
         end
         if (!lane_mask[ln]) r.flags[1] = 1;
         if (hdr_on && d.pid[63:56] != 0) begin
            r.kind = lesc_pkg::KIND_TRANSITION;
            r.flags = 0;
         end else begin
            if (hdr_on) begin
               r.pstep = d.pid - lane_pid[ln];
               if (d.pid < lane_pid[ln]) r.flags[4] = 1;
               lane_pid[ln] = d.pid;
               if (r.pstep != lane_pstep[ln]) begin
                  r.flags[5] = 1;
                  lane_pstep[ln] = r.pstep;
               end
               if (d.ts < lane_ts[ln]) r.flags[6] = 1;
               lane_ts[ln] = d.ts;
               r.cstep = {8'd0, ec} - {8'd0, lane_count[ln]};
               if (r.cstep != 1) r.flags[7] = 1;
               lane_count[ln] = ec;
            end
            if (d.pkt < lane_pkt[ln]) r.flags[2] = 1;
            else if (d.pkt != lane_pkt[ln] + 32'd1) begin
               r.flags[3] = 1;
               n_drops += d.pkt - lane_pkt[ln] - 32'd1;
            end
            lane_pkt[ln] = d.pkt;
            if (r.flags != 0) n_exceptions++;
            slot_hist[d.slot]++;
            n_events++;
            n_bytes += d.size;
         end
      end
      r.events = n_events;
      r.bytes = n_bytes;
      r.misses = n_misses;
      r.drops = n_drops;
      r.exceptions = n_exceptions;
      r.slot_count = slot_hist[d.slot];
      return r;
   endfunction

   task automatic send_buffer(buffer_desc d);
      req_push <= 1;
      req_buffer_size <= d.size;
      req_destination <= d.dest;
      req_buffer_slot <= d.slot;
      req_pulse_id <= d.pid;
      req_time_stamp <= d.ts;
      req_event_word <= d.evw;
      req_packet_counter <= d.pkt;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      if (!quiet && $urandom_range(99) < 11) begin
         req_push <= 0;
         @(negedge clock);
      end
   endtask

   task automatic write_csr(lesc_pkg::csr_index_type idx, logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == lesc_pkg::CSR_LANE_ENABLE) lane_mask = val[7:0];
      else hdr_on = val[0];
      @(negedge clock);
      csr_valid <= 0;
      @(negedge clock);
   endtask

   task automatic drain();
      req_push <= 0;
      while (expected_reports.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // receiver side
   always @(posedge clock) begin
      lane_report e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_reports.size() == 0) begin
            $error("result with nothing expected");
            errors++;
         end else begin
            e = expected_reports.pop_front();
            if (rsp_item_kind != e.kind) begin
               $error("item_kind exp %0d got %0d", e.kind, rsp_item_kind); errors++;
            end
            if (rsp_check_flags != e.flags) begin
               $error("check_flags exp %h got %h", e.flags, rsp_check_flags); errors++;
            end
            if (rsp_pulse_step != e.pstep) begin
               $error("pulse_step exp %h got %h", e.pstep, rsp_pulse_step); errors++;
            end
            if (rsp_count_step != e.cstep) begin
               $error("count_step exp %h got %h", e.cstep, rsp_count_step); errors++;
            end
            if (rsp_total_events != e.events) begin
               $error("total_events exp %0d got %0d", e.events, rsp_total_events); errors++;
            end
            if (rsp_total_bytes != e.bytes) begin
               $error("total_bytes exp %0d got %0d", e.bytes, rsp_total_bytes); errors++;
            end
            if (rsp_total_misses != e.misses) begin
               $error("total_misses exp %0d got %0d", e.misses, rsp_total_misses); errors++;
            end
            if (rsp_total_drops != e.drops) begin
               $error("total_drops exp %0d got %0d", e.drops, rsp_total_drops); errors++;
            end
            if (rsp_total_exceptions != e.exceptions) begin
               $error("total_exceptions exp %0d got %0d", e.exceptions,
                      rsp_total_exceptions);
               errors++;
            end
            if (rsp_slot_use_count != e.slot_count) begin
               $error("slot_use_count exp %0d got %0d", e.slot_count, rsp_slot_use_count);
               errors++;
            end
         end
      end
   end

   // expectations are queued on the input transfer
   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         buffer_desc d;
         d.size = req_buffer_size; d.dest = req_destination; d.slot = req_buffer_slot;
         d.pid = req_pulse_id; d.ts = req_time_stamp; d.evw = req_event_word;
         d.pkt = req_packet_counter;
         expected_reports.push_back(check_buffer(d));
      end
   end

   initial begin
      forever begin
         @(negedge clock);
         if (hold_off) rsp_pop <= 0;
         else rsp_pop <= quiet || ($urandom_range(99) >= 11);
      end
   end

   // long receiver stall while the sender keeps pushing
   task automatic stall_receiver();
      int n;
      hold_off = 1;
      for (n = 0; n < 60; n++) @(negedge clock);
      hold_off = 0;
   endtask

   function automatic buffer_desc random_desc(int ln, ref logic [63:0] pid,
                                              ref logic [63:0] ts,
                                              ref logic [23:0] ec, ref logic [31:0] pkt);
      buffer_desc d;
      int r;
      r = $urandom_range(99);
      pid += 64'd3; ts += 64'($urandom_range(100)); ec++; pkt++;
      d.size = ($urandom_range(7) == 0) ? 22'($urandom) : 22'(64 + ln);
      d.dest = {3'(ln), 5'($urandom)};
      d.slot = 6'($urandom);
      d.pid = pid; d.ts = ts; d.evw = {8'($urandom), ec}; d.pkt = pkt;
      if (r < 4) d.size = 0;
      else if (r < 8) d.pid = {8'($urandom_range(255, 1)), 56'($urandom)};
      else if (r < 12) d.pkt = $urandom;
      else if (r < 15) d.pid = {$urandom, $urandom} >> 8;
      else if (r < 18) d.ts = {$urandom, $urandom};
      else if (r < 21) d.evw = $urandom;
      else if (r < 23) d.dest = 8'($urandom);
      else if (r < 25) begin
         d.size = 22'd2097152;
         d.pid = {$urandom, $urandom};
      end
      return d;
   endfunction

   directed_row rows[$];

   initial begin
      lane_report z;
      logic [63:0] pids [8];
      logic [63:0] tss [8];
      logic [23:0] ecs [8];
      logic [31:0] pkts [8];
      int i, ln, ph;

      lane_mask = 8'd1; hdr_on = 0;
      for (i = 0; i < 8; i++) begin
         lane_size[i] = 0; lane_pid[i] = 0; lane_pstep[i] = 0; lane_ts[i] = 0;
         lane_count[i] = 0; lane_pkt[i] = 0;
         pids[i] = 0; tss[i] = 0; ecs[i] = 0; pkts[i] = 0;
      end
      for (i = 0; i < 64; i++) slot_hist[i] = 0;
      n_events = 0; n_bytes = 0; n_misses = 0; n_drops = 0; n_exceptions = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed part, header off then on
      z = '{lesc_pkg::KIND_MISS, 8'h00, 64'd0, 32'd0, 32'd0, 64'd0, 32'd1, 32'd0,
            32'd0, 32'd0};
      rows.push_back('{'{22'd0, 8'hff, 6'd63, '1, '1, '1, '1}, 1, z});
      z = '{lesc_pkg::KIND_EVENT, 8'h01, 64'd0, 32'd0, 32'd1, 64'd2097152, 32'd1, 32'd0,
            32'd1, 32'd1};
      rows.push_back('{'{22'd2097152, 8'h00, 6'd0, 64'd0, 64'd0, 32'd0, 32'd1}, 1, z});
      rows.push_back('{'{22'h3fffff, 8'hff, 6'd63, '1, '1, '1, '1}, 0, z});
      rows.push_back('{'{22'd1, 8'h1f, 6'd5, 64'd0, 64'd0, 32'd0, 32'd0}, 0, z});
      rows.push_back('{'{22'd1, 8'h1f, 6'd5, 64'd0, 64'd0, 32'd0, 32'd5}, 0, z});
      rows.push_back('{'{22'd1, 8'h20, 6'd2, 64'd0, 64'd0, 32'd0, 32'd1}, 0, z});
      rows.push_back('{'{22'd0, 8'h20, 6'd5, 64'd0, 64'd0, 32'd0, 32'd0}, 0, z});
      foreach (rows[i]) send_buffer(rows[i].desc);
      drain();
      write_csr(lesc_pkg::CSR_LANE_ENABLE, 32'h000000ff);
      write_csr(lesc_pkg::CSR_EXPECT_HEADER, 32'd1);
      rows.delete();
      rows.push_back('{'{22'd8, 8'h40, 6'd1, 64'd10, 64'd5, 32'h01000001, 32'd1}, 0, z});
      rows.push_back('{'{22'd8, 8'h40, 6'd1, 64'd13, 64'd6, 32'h00000002, 32'd2}, 0, z});
      rows.push_back('{'{22'd8, 8'h40, 6'd1, 64'd16, 64'd7, 32'h00000003, 32'd3}, 0, z});
      rows.push_back('{'{22'd9, 8'h40, 6'd1, 64'h0100000000000000, 64'd0, 32'd0, 32'd0},
                       0, z});
      rows.push_back('{'{22'd8, 8'h40, 6'd1, 64'd12, 64'd1, 32'h00000000, 32'd1}, 0, z});
      rows.push_back('{'{22'd8, 8'hc0, 6'd9, 64'h00ffffffffffffff, '1, 32'h00ffffff,
                        32'hffffffff}, 0, z});
      rows.push_back('{'{22'd8, 8'hc0, 6'd9, 64'd0, 64'd0, 32'h0, 32'h0}, 0, z});
      rows.push_back('{'{22'd8, 8'hc0, 6'd9, '1, '1, '1, '1}, 0, z});
      for (i = 0; i < rows.size(); i++) send_buffer(rows[i].desc);
      drain();

      // random part, every result checked by the receiver against the predictor
      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_csr(lesc_pkg::CSR_EXPECT_HEADER, 32'd0);
               write_csr(lesc_pkg::CSR_LANE_ENABLE, 0);
            end
            1: begin
               write_csr(lesc_pkg::CSR_EXPECT_HEADER, 32'd1);
               write_csr(lesc_pkg::CSR_LANE_ENABLE, 255);
            end
            2: write_csr(lesc_pkg::CSR_LANE_ENABLE, $urandom);
            3: begin
               write_csr(lesc_pkg::CSR_EXPECT_HEADER, 32'd0);
               write_csr(lesc_pkg::CSR_LANE_ENABLE, 255);
            end
            4: begin
               write_csr(lesc_pkg::CSR_EXPECT_HEADER, 32'd1);
               write_csr(lesc_pkg::CSR_LANE_ENABLE, 1);
            end
            default: write_csr(lesc_pkg::CSR_LANE_ENABLE, $urandom);
         endcase
         quiet = (ph == 3);
         for (i = 0; i < 255; i++) begin
            if (ph == 1 && i == 20) fork stall_receiver(); join_none
            ln = $urandom_range(7);
            send_buffer(random_desc(ln, pids[ln], tss[ln], ecs[ln], pkts[ln]));
         end
         quiet = 0;
         drain();
      end

      if (errors == 0) $display("tb_top: clean");
      else $display("tb_top: errors");
      $finish;
   end

   // first directed rows also carry a typed-in expectation; check those on output
   int row_seen = 0;
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (row_seen < 2 && rows.size() > row_seen && rows[row_seen].known) begin
            if (rsp_item_kind != rows[row_seen].want.kind) begin
               $error("item_kind exp %0d got %0d", rows[row_seen].want.kind,
                      rsp_item_kind);
               errors++;
            end
            if (rsp_total_misses != rows[row_seen].want.misses) begin
               $error("total_misses exp %0d got %0d", rows[row_seen].want.misses,
                      rsp_total_misses);
               errors++;
            end
            if (rsp_total_events != rows[row_seen].want.events) begin
               $error("total_events exp %0d got %0d", rows[row_seen].want.events,
                      rsp_total_events);
               errors++;
            end
            if (rsp_total_bytes != rows[row_seen].want.bytes) begin
               $error("total_bytes exp %0d got %0d", rows[row_seen].want.bytes,
                      rsp_total_bytes);
               errors++;
            end
            if (rsp_slot_use_count != rows[row_seen].want.slot_count) begin
               $error("slot_use_count exp %0d got %0d", rows[row_seen].want.slot_count,
                      rsp_slot_use_count);
               errors++;
            end
         end
         row_seen++;
      end
   end

   initial begin
      #2000000;
      $display("tb_top: errors");
      $finish;
   end

endmodule
